[rtl/per_node_reading_aggregator_assert.svh]
// Assertion macros for the per-node reading aggregator.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef PER_NODE_READING_AGGREGATOR_ASSERT_SVH
`define PER_NODE_READING_AGGREGATOR_ASSERT_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge out of reset.
`define PNRA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Implication whose consequent is checked in the next cycle.
`define PNRA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define PNRA_ASSERT(lbl, prop, msg)
`define PNRA_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

[rtl/pnra_pkg.sv]
// Shared types, constants and character helpers of the per-node reading aggregator.
// No dependencies.
package pnra_pkg;

  localparam int unsigned MaxMessagesDef = 10;
  localparam int unsigned IdCharsDef     = 7;
  localparam int unsigned ValueBitsDef   = 16;

  localparam int unsigned KeyBytes = 7;
  localparam int unsigned KeyW     = 8 * KeyBytes;
  localparam int unsigned KeyLenW  = 3;
  localparam int unsigned SumW     = 20;
  localparam int unsigned OutValW  = 16;
  localparam int unsigned CountW   = 4;
  localparam logic [SumW-1:0] SumMax = '1;

  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharComma = 8'h2C;
  localparam logic [7:0] CharDash  = 8'h2D;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRD,
    ST_SCMP,
    ST_SUPD,
    ST_FRD,
    ST_FOUT,
    ST_FEMPTY
  } state_e;

  typedef enum logic [1:0] {
    PH_PRE_ID,
    PH_ID,
    PH_GAP,
    PH_VALUE
  } phase_e;

  typedef enum logic [1:0] {
    VS_LEAD,
    VS_DIGITS,
    VS_DONE
  } vsub_e;

  function automatic logic is_delim(input logic [7:0] c);
    return (c == CharSpace) || (c == CharComma) || (c == CharDot) || (c == CharDash);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c inside {[CharTab:CharCr]};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[CharZero:CharNine]};
  endfunction

endpackage

[rtl/pnra_in_if.sv]
// Message byte / flush request channel of the per-node reading aggregator.
// Depends on nothing.
interface pnra_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, op, data_byte, end_of_message, input ready);
  modport sink   (input valid, op, data_byte, end_of_message, output ready);
endinterface

[rtl/pnra_out_if.sv]
// Aggregate result channel of the per-node reading aggregator.
// Depends on nothing.
interface pnra_out_if;
  logic        valid;
  logic        ready;
  logic [55:0] node_key;
  logic [2:0]  key_length;
  logic        key_truncated;
  logic [19:0] value_sum;
  logic [15:0] value_max;
  logic [15:0] value_min;
  logic [3:0]  entry_count;
  logic        last;

  modport source (output valid, node_key, key_length, key_truncated, value_sum, value_max,
                  value_min, entry_count, last, input ready);
  modport sink   (input valid, node_key, key_length, key_truncated, value_sum, value_max,
                  value_min, entry_count, last, output ready);
endinterface

[rtl/per_node_reading_aggregator.sv]
// Per-node reading aggregator: byte parser, ID table sequencer and result register.
// Depends on pnra_pkg, pnra_in_if, pnra_out_if, pnra_ram and the assertion header.

// The byte that ends a message starts a search of the ID table, which sits in a
// RAM with registered read and goes through one shared compare/update unit: each
// stored ID is read (ST_SRD) and compared (ST_SCMP), a miss passes ST_SRD once
// more, and the write is done in ST_SUPD before the next request is taken. A
// flush, or the message that fills the table, emits the stored results in turn,
// each read in ST_FRD and loaded in ST_FOUT, which waits while the output is not
// free; an empty table gives one all-zero result. The input waits until the final
// result (flagged last) is loaded. The output register holds a result while new
// message bytes are still taken; bytes are taken only in ST_IDLE.
`include "per_node_reading_aggregator_assert.svh"

module per_node_reading_aggregator #(
  parameter int unsigned MAX_MESSAGES = pnra_pkg::MaxMessagesDef,
  parameter int unsigned ID_CHARS     = pnra_pkg::IdCharsDef,
  parameter int unsigned VALUE_BITS   = pnra_pkg::ValueBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pnra_in_if.sink     msg_i,
  pnra_out_if.source  res_o
);

  localparam int unsigned AddrW  = (MAX_MESSAGES > 1) ? $clog2(MAX_MESSAGES) : 1;
  localparam int unsigned CntW   = $clog2(MAX_MESSAGES + 1);
  localparam int unsigned VB     = VALUE_BITS;
  localparam int unsigned KeyW   = pnra_pkg::KeyW;
  localparam int unsigned LenW   = pnra_pkg::KeyLenW;
  localparam int unsigned SumW   = pnra_pkg::SumW;
  localparam int unsigned CountW = pnra_pkg::CountW;
  localparam int unsigned EntryW = KeyW + 1 + LenW + SumW + 2 * VB + CountW;
  localparam int unsigned AccW   = ((VB > SumW) ? VB : SumW) + 1;
  localparam logic [VB-1:0] ValueMax = '1;

  // Parser state
  pnra_pkg::phase_e                          phase_q, phase_d;
  pnra_pkg::vsub_e                           vsub_q, vsub_d;
  logic                                      halt_q, halt_d;
  logic                                      trunc_q, trunc_d;
  logic [pnra_pkg::KeyBytes-1:0][7:0]        key_q, key_d;
  logic [LenW-1:0]                           klen_q, klen_d;
  logic [VB-1:0]                             val_q, val_d;

  // Message under search
  logic [KeyW-1:0] s_key_q;
  logic            s_trunc_q;
  logic [LenW-1:0] s_len_q;
  logic [VB-1:0]   s_val_q;

  // Sequencer
  pnra_pkg::state_e state_q, state_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic [CntW-1:0]  fill_q, fill_d;
  logic [CntW-1:0]  mcnt_q, mcnt_d;
  logic             found_q, found_d;

  // Output register
  logic              out_valid_q;
  logic [KeyW-1:0]   out_key_q;
  logic [LenW-1:0]   out_len_q;
  logic              out_trunc_q;
  logic [SumW-1:0]   out_sum_q;
  logic [15:0]       out_max_q;
  logic [15:0]       out_min_q;
  logic [CountW-1:0] out_cnt_q;
  logic              out_last_q;

  logic in_acc;
  logic out_free;
  logic out_load;
  logic out_empty;
  logic out_last;
  logic ram_we;

  logic [7:0] c;
  logic [VB+3:0] prod;
  logic [VB-1:0] digit_val;

  logic [EntryW-1:0] rdata;
  logic [EntryW-1:0] wdata;
  logic [KeyW-1:0]   r_key;
  logic              r_trunc;
  logic [LenW-1:0]   r_len;
  logic [SumW-1:0]   r_sum;
  logic [VB-1:0]     r_max;
  logic [VB-1:0]     r_min;
  logic [CountW-1:0] r_cnt;
  logic              hit;
  logic [AccW-1:0]   acc;
  logic [SumW-1:0]   new_sum;
  logic [VB-1:0]     new_max;
  logic [VB-1:0]     new_min;
  logic [CountW-1:0] new_cnt;

  assign msg_i.ready = (state_q == pnra_pkg::ST_IDLE);
  assign in_acc      = msg_i.valid && msg_i.ready;
  assign out_free    = !out_valid_q || res_o.ready;
  assign c           = msg_i.data_byte;

  // Decimal accumulate with saturation: val * 10 + digit
  assign prod = ({4'b0, val_q} << 3) + ({4'b0, val_q} << 1) + (VB + 4)'(c - pnra_pkg::CharZero);
  assign digit_val = (|prod[VB+3:VB]) ? ValueMax : prod[VB-1:0];

  // Parser next state
  always_comb begin
    phase_d   = phase_q;
    vsub_d    = vsub_q;
    halt_d    = halt_q;
    trunc_d   = trunc_q;
    key_d     = key_q;
    klen_d    = klen_q;
    val_d     = val_q;
    if (!halt_q) begin
      if (c == pnra_pkg::CharNul) begin
        halt_d = 1'b1;
      end else begin
        case (phase_q)
          pnra_pkg::PH_PRE_ID, pnra_pkg::PH_ID: begin
            if (pnra_pkg::is_delim(c)) begin
              if (phase_q == pnra_pkg::PH_ID) begin
                phase_d = pnra_pkg::PH_GAP;
              end
            end else begin
              phase_d = pnra_pkg::PH_ID;
              if (klen_q < LenW'(ID_CHARS)) begin
                key_d[LenW'(pnra_pkg::KeyBytes - 1) - klen_q] = c;
                klen_d = klen_q + 1'b1;
              end else begin
                trunc_d = 1'b1;
              end
            end
          end
          pnra_pkg::PH_GAP: begin
            if (!pnra_pkg::is_delim(c)) begin
              phase_d = pnra_pkg::PH_VALUE;
              if (pnra_pkg::is_digit(c)) begin
                val_d  = digit_val;
                vsub_d = pnra_pkg::VS_DIGITS;
              end else if (pnra_pkg::is_blank(c)) begin
                vsub_d = pnra_pkg::VS_LEAD;
              end else if (c == pnra_pkg::CharPlus) begin
                vsub_d = pnra_pkg::VS_DIGITS;
              end else begin
                vsub_d = pnra_pkg::VS_DONE;
              end
            end
          end
          default: begin
            if (pnra_pkg::is_delim(c)) begin
              vsub_d = pnra_pkg::VS_DONE;
            end else if (vsub_q != pnra_pkg::VS_DONE) begin
              if (pnra_pkg::is_digit(c)) begin
                val_d  = digit_val;
                vsub_d = pnra_pkg::VS_DIGITS;
              end else if (vsub_q == pnra_pkg::VS_LEAD && pnra_pkg::is_blank(c)) begin
                vsub_d = pnra_pkg::VS_LEAD;
              end else if (vsub_q == pnra_pkg::VS_LEAD && c == pnra_pkg::CharPlus) begin
                vsub_d = pnra_pkg::VS_DIGITS;
              end else begin
                vsub_d = pnra_pkg::VS_DONE;
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= pnra_pkg::PH_PRE_ID;
      vsub_q  <= pnra_pkg::VS_LEAD;
      halt_q  <= 1'b0;
      trunc_q <= 1'b0;
      key_q   <= '0;
      klen_q  <= '0;
      val_q   <= '0;
    end else if (in_acc && !msg_i.op) begin
      if (msg_i.end_of_message) begin
        // Message done: clear for the next one
        phase_q <= pnra_pkg::PH_PRE_ID;
        vsub_q  <= pnra_pkg::VS_LEAD;
        halt_q  <= 1'b0;
        trunc_q <= 1'b0;
        key_q   <= '0;
        klen_q  <= '0;
        val_q   <= '0;
      end else begin
        phase_q <= phase_d;
        vsub_q  <= vsub_d;
        halt_q  <= halt_d;
        trunc_q <= trunc_d;
        key_q   <= key_d;
        klen_q  <= klen_d;
        val_q   <= val_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && !msg_i.op && msg_i.end_of_message) begin
      s_key_q   <= key_d;
      s_trunc_q <= trunc_d;
      s_len_q   <= klen_d;
      s_val_q   <= val_d;
    end
  end

  // ID table
  pnra_ram #(
    .Width (EntryW),
    .Depth (MAX_MESSAGES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q[AddrW-1:0]),
    .wdata_i (wdata),
    .raddr_i (idx_q[AddrW-1:0]),
    .rdata_o (rdata)
  );

  assign {r_key, r_trunc, r_len, r_sum, r_max, r_min, r_cnt} = rdata;

  // Shared compare / update unit
  assign hit     = ({r_trunc, r_key} == {s_trunc_q, s_key_q});
  assign acc     = AccW'(found_q ? r_sum : '0) + AccW'(s_val_q);
  assign new_sum = (acc > AccW'(pnra_pkg::SumMax)) ? pnra_pkg::SumMax : acc[SumW-1:0];
  assign new_max = (found_q && r_max >= s_val_q) ? r_max : s_val_q;
  assign new_min = (found_q && r_min <= s_val_q) ? r_min : s_val_q;
  assign new_cnt = found_q ? r_cnt + 1'b1 : CountW'(1);
  assign wdata   = {s_key_q, s_trunc_q, s_len_q, new_sum, new_max, new_min, new_cnt};

  // Sequencer
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    fill_d    = fill_q;
    mcnt_d    = mcnt_q;
    found_d   = found_q;
    ram_we    = 1'b0;
    out_load  = 1'b0;
    out_empty = 1'b0;
    out_last  = 1'b0;
    case (state_q)
      pnra_pkg::ST_IDLE: begin
        if (in_acc) begin
          idx_d = '0;
          if (msg_i.op) begin
            state_d = (fill_q == '0) ? pnra_pkg::ST_FEMPTY : pnra_pkg::ST_FRD;
          end else if (msg_i.end_of_message) begin
            state_d = pnra_pkg::ST_SRD;
          end
        end
      end
      pnra_pkg::ST_SRD: begin
        if (idx_q == fill_q) begin
          found_d = 1'b0;
          state_d = pnra_pkg::ST_SUPD;
        end else begin
          state_d = pnra_pkg::ST_SCMP;
        end
      end
      pnra_pkg::ST_SCMP: begin
        if (hit) begin
          found_d = 1'b1;
          state_d = pnra_pkg::ST_SUPD;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = pnra_pkg::ST_SRD;
        end
      end
      pnra_pkg::ST_SUPD: begin
        ram_we = 1'b1;
        if (!found_q) begin
          fill_d = fill_q + 1'b1;
        end
        mcnt_d = mcnt_q + 1'b1;
        if (mcnt_q == CntW'(MAX_MESSAGES - 1)) begin
          idx_d   = '0;
          state_d = pnra_pkg::ST_FRD;
        end else begin
          state_d = pnra_pkg::ST_IDLE;
        end
      end
      pnra_pkg::ST_FRD: begin
        state_d = pnra_pkg::ST_FOUT;
      end
      pnra_pkg::ST_FOUT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (idx_q == fill_q - 1'b1) begin
            out_last = 1'b1;
            fill_d   = '0;
            mcnt_d   = '0;
            state_d  = pnra_pkg::ST_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = pnra_pkg::ST_FRD;
          end
        end
      end
      pnra_pkg::ST_FEMPTY: begin
        if (out_free) begin
          out_load  = 1'b1;
          out_empty = 1'b1;
          out_last  = 1'b1;
          mcnt_d    = '0;
          state_d   = pnra_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pnra_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pnra_pkg::ST_IDLE;
      idx_q   <= '0;
      fill_q  <= '0;
      mcnt_q  <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      fill_q  <= fill_d;
      mcnt_q  <= mcnt_d;
      found_q <= found_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_last_q <= out_last;
      if (out_empty) begin
        out_key_q   <= '0;
        out_len_q   <= '0;
        out_trunc_q <= 1'b0;
        out_sum_q   <= '0;
        out_max_q   <= '0;
        out_min_q   <= '0;
        out_cnt_q   <= '0;
      end else begin
        out_key_q   <= r_key;
        out_len_q   <= r_len;
        out_trunc_q <= r_trunc;
        out_sum_q   <= r_sum;
        out_max_q   <= pnra_pkg::OutValW'(r_max);
        out_min_q   <= pnra_pkg::OutValW'(r_min);
        out_cnt_q   <= r_cnt;
      end
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.node_key      = out_key_q;
  assign res_o.key_length    = out_len_q;
  assign res_o.key_truncated = out_trunc_q;
  assign res_o.value_sum     = out_sum_q;
  assign res_o.value_max     = out_max_q;
  assign res_o.value_min     = out_min_q;
  assign res_o.entry_count   = out_cnt_q;
  assign res_o.last          = out_last_q;

  `PNRA_ASSERT(a_fill_le_count, fill_q <= mcnt_q, "table holds more IDs than messages stored")
  `PNRA_ASSERT(a_count_below_max, (mcnt_q < CntW'(MAX_MESSAGES)) || (state_q == pnra_pkg::ST_FRD) || (state_q == pnra_pkg::ST_FOUT), "message count reached limit without flush")
  `PNRA_ASSERT(a_cmp_in_range, (state_q != pnra_pkg::ST_SCMP) || (idx_q < fill_q), "compare beyond filled entries")
  `PNRA_ASSERT_NEXT(a_flush_nonempty, state_q == pnra_pkg::ST_FRD, state_q == pnra_pkg::ST_FOUT && fill_q != '0, "flush read without stored IDs")

endmodule

[rtl/pnra_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pnra_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
